// ===== rtl/fys_pkg.sv =====
// Package for the Fisher-Yates shuffle step block: widths, types, constants
// and the deck count clamp. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package fys_pkg;

    localparam int DECK_SLOTS = 64;
    localparam int POS_W      = $clog2(DECK_SLOTS);
    localparam int CARD_W     = 6;
    localparam int COUNT_W    = 7;
    localparam int WORD_W     = 32;
    localparam int DIV_STEP   = 8;
    localparam int DIV_CYCLES = WORD_W / DIV_STEP;
    localparam int DIV_CNT_W  = $clog2(DIV_CYCLES);

    typedef logic [POS_W-1:0]   pos_t;
    typedef logic [CARD_W-1:0]  card_t;
    typedef logic [COUNT_W-1:0] count_t;
    typedef logic [WORD_W-1:0]  word_t;

    localparam count_t COUNT_RESET = count_t'(52);
    localparam count_t COUNT_MIN   = count_t'(2);
    localparam count_t COUNT_MAX   = count_t'(DECK_SLOTS);

    function automatic count_t eff_count(input count_t c);
        count_t n;
        n = c;
        if (n < COUNT_MIN)
        begin
            n = COUNT_MIN;
        end
        if (n > COUNT_MAX)
        begin
            n = COUNT_MAX;
        end
        return n;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/fys_channels.sv =====
// Valid/ready channel interfaces of the shuffle step block: random words in,
// step results out, deck count writes. Depends on fys_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface fys_word_if;
    import fys_pkg::*;
    logic  valid;
    logic  ready;
    word_t random_word;
    modport source (output valid, output random_word, input ready);
    modport sink (input valid, input random_word, output ready);
endinterface

interface fys_step_if;
    import fys_pkg::*;
    logic  valid;
    logic  ready;
    pos_t  position;
    card_t card;
    logic  pass_done;
    modport source (output valid, output position, output card, output pass_done, input ready);
    modport sink (input valid, input position, input card, input pass_done, output ready);
endinterface

interface fys_cfg_if;
    import fys_pkg::*;
    logic   valid;
    logic   ready;
    count_t deck_count;
    modport source (output valid, output deck_count, input ready);
    modport sink (input valid, input deck_count, output ready);
endinterface

`default_nettype wire

// ===== rtl/fisher_yates_shuffle_step.sv =====
// Top level of the Fisher-Yates shuffle step block.
// Depends on fys_pkg and the channel interfaces in fys_channels.sv.
//
// Each random word beat fixes one deck position: the partner index comes from
// the word modulo the cards left, then the two deck entries swap and the new
// card at the position goes out as one result beat. A word is taken in idle,
// then passes through the remainder unit (8 quotient bits a cycle), a read of
// both entries from the deck memory and the two writes of the swap through its
// single write port; no new word is taken until the step is back in idle. The
// result sits in an output register, so the next word is taken while it waits;
// a result still waiting when the next step reaches its last write holds it
// there. The deck needs no clearing pass: per-entry valid bits make unwritten
// entries read as identity order right after reset. A deck_count write is
// taken only when no step is running and no result waits, and a waiting write
// holds off new words; it returns the position to 0 and keeps the deck.
`timescale 1ns / 1ps
`default_nettype none

module fisher_yates_shuffle_step
(
    input  logic       clk,
    input  logic       rst_n,
    fys_cfg_if.sink    cfg,
    fys_word_if.sink   words,
    fys_step_if.source steps
);
    import fys_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_DIV  = 3'd1;
    localparam logic [2:0] S_RD   = 3'd2;
    localparam logic [2:0] S_WRI  = 3'd3;
    localparam logic [2:0] S_WRJ  = 3'd4;

    logic [2:0]           state_reg;
    logic [2:0]           state_next;
    count_t               count_reg;
    pos_t                 pos_reg;
    logic [DIV_CNT_W-1:0] div_cnt_reg;
    word_t                dvd_reg;
    count_t               rem_reg;
    count_t               dsr_reg;
    pos_t                 i_reg;
    pos_t                 j_reg;
    logic                 last_reg;

    card_t                mem [DECK_SLOTS];
    logic [DECK_SLOTS-1:0] vld_reg;
    card_t                rdi_reg;
    card_t                rdj_reg;
    logic                 vldi_reg;
    logic                 vldj_reg;

    logic                 out_valid_reg;
    pos_t                 out_pos_reg;
    card_t                out_card_reg;
    logic                 out_done_reg;

    count_t               n_eff;
    pos_t                 i_cur;
    pos_t                 j_cur;
    count_t               rem_step;
    card_t                di;
    card_t                dj;
    logic                 mem_we;
    pos_t                 mem_waddr;
    card_t                mem_wdata;
    logic                 out_free;
    logic                 accept;

    assign cfg.ready       = (state_reg == S_IDLE) && !out_valid_reg;
    assign words.ready     = (state_reg == S_IDLE) && !cfg.valid;
    assign accept          = words.valid && words.ready;
    assign steps.valid     = out_valid_reg;
    assign steps.position  = out_pos_reg;
    assign steps.card      = out_card_reg;
    assign steps.pass_done = out_done_reg;

    assign n_eff    = eff_count(count_reg);
    assign i_cur    = ({1'b0, pos_reg} >= n_eff) ? '0 : pos_reg;
    assign j_cur    = i_reg + rem_reg[POS_W-1:0];
    assign di       = vldi_reg ? rdi_reg : card_t'(i_reg);
    assign dj       = vldj_reg ? rdj_reg : card_t'(j_reg);
    assign out_free = !out_valid_reg || steps.ready;

    assign mem_we    = (state_reg == S_WRI) || (state_reg == S_WRJ);
    assign mem_waddr = (state_reg == S_WRI) ? i_reg : j_reg;
    assign mem_wdata = (state_reg == S_WRI) ? dj : di;

    always_comb
    begin
        rem_step = rem_reg;
        for (int k = 0; k < DIV_STEP; k++)
        begin
            rem_step = {rem_step[COUNT_W-2:0], dvd_reg[WORD_W-1-k]};
            if (rem_step >= dsr_reg)
            begin
                rem_step = rem_step - dsr_reg;
            end
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                if (div_cnt_reg == DIV_CNT_W'(DIV_CYCLES - 1))
                begin
                    state_next = S_RD;
                end
            end
            S_RD:
            begin
                state_next = S_WRI;
            end
            S_WRI:
            begin
                state_next = S_WRJ;
            end
            S_WRJ:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= COUNT_RESET;
            pos_reg       <= '0;
            div_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
            vld_reg       <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg.valid && cfg.ready)
            begin
                count_reg <= cfg.deck_count;
                pos_reg   <= '0;
            end
            if (accept)
            begin
                div_cnt_reg <= '0;
            end
            else if (state_reg == S_DIV)
            begin
                div_cnt_reg <= div_cnt_reg + DIV_CNT_W'(1);
            end
            if (mem_we)
            begin
                vld_reg[mem_waddr] <= 1'b1;
            end
            if (state_reg == S_WRJ && out_free)
            begin
                out_valid_reg <= 1'b1;
                pos_reg       <= last_reg ? '0 : i_reg + POS_W'(1);
            end
            else if (steps.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            i_reg    <= i_cur;
            dsr_reg  <= n_eff - {1'b0, i_cur};
            rem_reg  <= '0;
            dvd_reg  <= words.random_word;
            last_reg <= ({1'b0, i_cur} + count_t'(1)) >= n_eff;
        end
        else if (state_reg == S_DIV)
        begin
            rem_reg <= rem_step;
            dvd_reg <= dvd_reg << DIV_STEP;
        end
        if (state_reg == S_RD)
        begin
            j_reg <= j_cur;
        end
        if (state_reg == S_WRJ && out_free)
        begin
            out_pos_reg  <= i_reg;
            out_card_reg <= dj;
            out_done_reg <= last_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (state_reg == S_RD)
        begin
            rdi_reg  <= mem[i_reg];
            rdj_reg  <= mem[j_cur];
            vldi_reg <= vld_reg[i_reg];
            vldj_reg <= vld_reg[j_cur];
        end
    end

endmodule

`default_nettype wire

// ===== rtl/fys_checker.sv =====
// Port-level checker for the shuffle step block and its bind to the top level.
// Depends on fys_pkg.
`timescale 1ns / 1ps
`default_nettype none

module fys_checker
(
    input logic              clk,
    input logic              rst_n,
    input logic              in_valid,
    input logic              in_ready,
    input logic              out_valid,
    input logic              out_ready,
    input fys_pkg::pos_t     position,
    input fys_pkg::card_t    card,
    input logic              pass_done,
    input logic              cfg_valid,
    input logic              cfg_ready,
    input fys_pkg::count_t   cfg_count
);
    import fys_pkg::*;

    count_t     count_reg;
    pos_t       exp_pos_reg;
    logic [1:0] pend_reg;
    logic       in_beat;
    logic       out_beat;
    count_t     n_eff;

    assign in_beat  = in_valid && in_ready;
    assign out_beat = out_valid && out_ready;
    assign n_eff    = eff_count(count_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg   <= COUNT_RESET;
            exp_pos_reg <= '0;
            pend_reg    <= '0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                count_reg   <= cfg_count;
                exp_pos_reg <= '0;
            end
            else if (out_beat)
            begin
                exp_pos_reg <= pass_done ? '0 : position + POS_W'(1);
            end
            pend_reg <= pend_reg + 2'(in_beat) - 2'(out_beat);
        end
    end

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(position) && $stable(card)
            && $stable(pass_done))
        else $error("result changed while stalled");

    a_no_invented: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> pend_reg != 2'd0)
        else $error("result without a pending word");

    a_position_order: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> position == exp_pos_reg)
        else $error("position out of sequence");

    a_pass_end: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> pass_done == ((count_t'(position) + count_t'(1)) == n_eff))
        else $error("pass_done does not match last position");

    a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
        in_beat |=> !in_ready)
        else $error("word taken while step in progress");

endmodule

bind fisher_yates_shuffle_step fys_checker u_fys_checker
(
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (words.valid),
    .in_ready  (words.ready),
    .out_valid (steps.valid),
    .out_ready (steps.ready),
    .position  (steps.position),
    .card      (steps.card),
    .pass_done (steps.pass_done),
    .cfg_valid (cfg.valid),
    .cfg_ready (cfg.ready),
    .cfg_count (cfg.deck_count)
);

`default_nettype wire

// ===== tb/sv/fys_shuffle_checker.sv =====
// Checker for the shuffle step block: tracks deck, position and count from the
// observed beats, predicts each step result and compares it field by field.
// Depends on fys_pkg and the channel interfaces in fys_channels.sv.
`timescale 1ns / 1ps

module fys_shuffle_checker
(
    input  logic clk,
    input  logic rst_n,
    fys_cfg_if   cfg,
    fys_word_if  words,
    fys_step_if  steps,
    output int   fail_count,
    output int   pending
);
    import fys_pkg::*;

    typedef struct packed {
        pos_t  position;
        card_t card;
        logic  pass_done;
    } step_result_t;

    card_t        deck [DECK_SLOTS];
    int unsigned  fix_pos;
    count_t       cards_in_use;
    step_result_t expected_steps [$];

    function automatic step_result_t shuffle_one(input word_t w);
        int unsigned  n;
        int unsigned  i;
        int unsigned  j;
        card_t        held;
        step_result_t s;
        n = cards_in_use;
        if (n < COUNT_MIN)
        begin
            n = COUNT_MIN;
        end
        if (n > COUNT_MAX)
        begin
            n = COUNT_MAX;
        end
        i = fix_pos;
        if (i >= n)
        begin
            i = 0;
        end
        j = i + (w % (n - i));
        if (j >= DECK_SLOTS)
        begin
            j = i;
        end
        held    = deck[i];
        deck[i] = deck[j];
        deck[j] = held;
        s.position  = pos_t'(i);
        s.card      = deck[i];
        s.pass_done = (i + 1 >= n);
        fix_pos     = s.pass_done ? 0 : i + 1;
        return s;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        step_result_t want;
        step_result_t next_step;
        if (!rst_n)
        begin
            for (int k = 0; k < DECK_SLOTS; k++)
            begin
                deck[k] = card_t'(k);
            end
            fix_pos      = 0;
            cards_in_use = COUNT_RESET;
            fail_count   = 0;
            expected_steps.delete();
        end
        else
        begin
            if (steps.valid && steps.ready)
            begin
                if (expected_steps.size() == 0)
                begin
                    $display("%0t: step beat pos=%0d card=%0d done=%0b with nothing expected",
                             $time, steps.position, steps.card, steps.pass_done);
                    fail_count++;
                end
                else
                begin
                    want = expected_steps.pop_front();
                    if (steps.position !== want.position)
                    begin
                        $display("%0t: position expected %0d got %0d",
                                 $time, want.position, steps.position);
                        fail_count++;
                    end
                    if (steps.card !== want.card)
                    begin
                        $display("%0t: card at %0d expected %0d got %0d",
                                 $time, want.position, want.card, steps.card);
                        fail_count++;
                    end
                    if (steps.pass_done !== want.pass_done)
                    begin
                        $display("%0t: pass_done at %0d expected %0b got %0b",
                                 $time, want.position, want.pass_done, steps.pass_done);
                        fail_count++;
                    end
                end
            end
            if (words.valid && words.ready)
            begin
                next_step = shuffle_one(words.random_word);
                expected_steps.insert(expected_steps.size(), next_step);
            end
            if (cfg.valid && cfg.ready)
            begin
                cards_in_use = cfg.deck_count;
                fix_pos      = 0;
            end
        end
        pending = expected_steps.size();
    end

endmodule

// ===== tb/sv/tb_fisher_yates_shuffle_step.sv =====
// Top of the shuffle step testbench: clock, reset, random word and deck count
// stimulus, result stalls and the verdict. Depends on fys_pkg, the channel
// interfaces, the shuffle step block and fys_shuffle_checker.
`timescale 1ns / 1ps

module tb_fisher_yates_shuffle_step;
    import fys_pkg::*;

    localparam int STEP_CYCLES  = 8;
    localparam int SETTLE       = 2 * STEP_CYCLES;
    localparam int SEGMENTS     = 8;
    localparam int SEG_WORDS    = 55;
    localparam int HOLDOFF_LEN  = 200;

    logic clk;
    logic rst_n;
    int   fail_count;
    int   pending;
    int   idle_pct;
    int   stall_pct;
    logic holdoff_req;

    fys_cfg_if  cfg_ch ();
    fys_word_if word_ch ();
    fys_step_if step_ch ();

    fisher_yates_shuffle_step dut
    (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg_ch),
        .words (word_ch),
        .steps (step_ch)
    );

    fys_shuffle_checker checker_i
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_ch),
        .words      (word_ch),
        .steps      (step_ch),
        .fail_count (fail_count),
        .pending    (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #5 clk = ~clk;
        end
    end

    initial
    begin
        #3ms;
        $display("== FAIL ==");
        $finish;
    end

    // result side: random stalls plus one long hold-off on request
    initial
    begin
        int unsigned hold_left;
        logic        hold_taken;
        hold_left     = 0;
        hold_taken    = 1'b0;
        step_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (holdoff_req && !hold_taken)
            begin
                hold_taken = 1'b1;
                hold_left  = HOLDOFF_LEN;
            end
            if (!rst_n)
            begin
                step_ch.ready = 1'b0;
            end
            else if (hold_left > 0)
            begin
                step_ch.ready = 1'b0;
                hold_left--;
            end
            else
            begin
                step_ch.ready = ($urandom_range(99) >= stall_pct);
            end
        end
    end

    function automatic word_t pick_word();
        int unsigned sel;
        sel = $urandom_range(99);
        if (sel < 60)
        begin
            return $urandom;
        end
        else if (sel < 80)
        begin
            return word_t'($urandom_range(255));
        end
        else if (sel < 90)
        begin
            return ~word_t'($urandom_range(255));
        end
        return word_t'($urandom_range(63)) << $urandom_range(26);
    endfunction

    task automatic send_word(input word_t w);
        while ($urandom_range(99) < idle_pct)
        begin
            word_ch.valid = 1'b0;
            @(negedge clk);
        end
        word_ch.valid       = 1'b1;
        word_ch.random_word = w;
        @(posedge clk);
        while (!word_ch.ready)
        begin
            @(posedge clk);
        end
        @(negedge clk);
    endtask

    task automatic write_count(input count_t c);
        word_ch.valid = 1'b0;
        while (pending != 0)
        begin
            @(negedge clk);
        end
        repeat (SETTLE) @(negedge clk);
        cfg_ch.valid      = 1'b1;
        cfg_ch.deck_count = c;
        @(posedge clk);
        while (!cfg_ch.ready)
        begin
            @(posedge clk);
        end
        @(negedge clk);
        cfg_ch.valid = 1'b0;
    endtask

    initial
    begin
        count_t seg_count;
        rst_n               = 1'b0;
        holdoff_req         = 1'b0;
        idle_pct            = 0;
        stall_pct           = 0;
        cfg_ch.valid        = 1'b0;
        cfg_ch.deck_count   = '0;
        word_ch.valid       = 1'b0;
        word_ch.random_word = '0;
        repeat (6) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // reset count, then count writes mid-pass, including out-of-range counts that clamp
        send_word('0);
        send_word('1);
        send_word(32'h8000_0000);
        send_word(32'h7FFF_FFFF);
        write_count(COUNT_MIN);
        send_word('1);
        send_word('1);
        send_word(32'h5555_5555);
        send_word(32'hAAAA_AAAA);
        write_count(count_t'(0));
        send_word('1);
        send_word('0);
        write_count(count_t'(1));
        send_word(32'h0000_0001);
        send_word('1);
        write_count(count_t'(3));
        send_word('1);
        send_word('1);
        send_word('1);
        send_word(32'h0000_0002);
        write_count('1);
        send_word('1);
        send_word(32'h0000_003F);
        write_count(COUNT_MAX);
        send_word(32'h0000_0040);
        send_word(32'hFFFF_FFC0);

        for (int seg = 0; seg < SEGMENTS; seg++)
        begin
            case (seg)
                0: seg_count = COUNT_MAX;
                1: seg_count = COUNT_MIN;
                2: seg_count = '1;
                3: seg_count = count_t'(1);
                5: seg_count = COUNT_RESET;
                6: seg_count = count_t'(33);
                default: seg_count = count_t'($urandom_range(127));
            endcase
            write_count(seg_count);
            case (seg % 4)
                0:
                begin
                    idle_pct  = 0;
                    stall_pct = 0;
                end
                1:
                begin
                    idle_pct  = 67;
                    stall_pct = 0;
                end
                2:
                begin
                    idle_pct  = 0;
                    stall_pct = 67;
                end
                default:
                begin
                    idle_pct  = 28;
                    stall_pct = 28;
                end
            endcase
            for (int n = 0; n < SEG_WORDS; n++)
            begin
                if (seg == 0 && n == 10)
                begin
                    holdoff_req = 1'b1;
                end
                send_word(pick_word());
            end
        end

        word_ch.valid = 1'b0;
        while (pending != 0)
        begin
            @(negedge clk);
        end
        repeat (SETTLE) @(negedge clk);
        if (fail_count == 0 && pending == 0)
        begin
            $display("== PASS ==");
        end
        else
        begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/fys_pkg.sv
rtl/fys_channels.sv
rtl/fisher_yates_shuffle_step.sv
rtl/fys_checker.sv
tb/sv/fys_shuffle_checker.sv
tb/sv/tb_fisher_yates_shuffle_step.sv
